FILE: rtl/core/upsh_pkg.sv
// Package for the unordered pair hash set.
// Holds payload types, action and status codes and hash constants.
// No dependencies.
`default_nettype none
package upsh_pkg;
  localparam int unsigned HashBitsDefault = 12;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNCHAINED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [63:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] id_a;
    logic [31:0] id_b;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  status;
    logic [10:0] entry_total;
  } out_t;
endpackage
`default_nettype wire

FILE: rtl/core/unordered_pair_hash_set.sv
// Unordered pair hash set: stores pairs of 32-bit ids and answers membership.
// Channels: in (in_valid_i/in_ready_o, in_data_i of upsh_pkg::in_t) and
// out (out_valid_o/out_ready_i, out_data_o of upsh_pkg::out_t). Every
// accepted item gives exactly one result, in order.
// One item is worked at a time; in_ready_o is high only when idle.
// An unused action, a query with a zero id, or an insert with a zero id or
// a full table, skips the hash. Chained insert and query run the hash (one
// shared 32x32 multiplier) and one bucket memory read, plus one entry memory
// read per chain link walked by a query.
// Clear sweeps all 2**HASH_BITS bucket words, one per cycle, then reports.
// After reset the same sweep runs before the first item is taken.
// The result sits in an output register; a stalled receiver holds it there
// and the next item's result waits until the register is free, while that
// item is already accepted and worked.
// Depends on upsh_pkg, upsh_ram, upsh_hash.
`default_nettype none
module unordered_pair_hash_set #(
  parameter int unsigned HASH_BITS = upsh_pkg::HashBitsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire upsh_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output upsh_pkg::out_t      out_data_o
);
  localparam int unsigned IdxW = upsh_pkg::IdxW;
  localparam int unsigned CntW = upsh_pkg::CntW;
  localparam logic [CntW-1:0] ChainEnd = CntW'(upsh_pkg::Capacity);
  localparam int unsigned EntW = 64 + CntW;
  localparam int unsigned BktW = 1 + IdxW;
  localparam int unsigned Buckets = 1 << HASH_BITS;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_HASH = 7'b0000100,
    S_BCHK = 7'b0001000,
    S_ECHK = 7'b0010000,
    S_DONE = 7'b0100000,
    S_ERD  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [HASH_BITS-1:0] sweep_q, sweep_d;
  logic item_q, item_d;
  logic [1:0] act_q, act_d;
  logic [31:0] lo_q, lo_d, hi_q, hi_d, lo_in, hi_in;
  logic [CntW+1:0] steps_q, steps_d;
  logic found_q, found_d;
  logic [1:0] status_q, status_d;
  logic out_valid_q, out_valid_d;
  upsh_pkg::out_t out_q, out_d;

  logic hash_start, hash_done;
  logic [HASH_BITS-1:0] bucket, bucket_q, bucket_d;

  logic b_we, b_re;
  logic [HASH_BITS-1:0] b_waddr;
  logic [BktW-1:0] b_wdata, b_rdata;
  logic e_we, e_re;
  logic [IdxW-1:0] e_raddr;
  logic [EntW-1:0] e_wdata, e_rdata;
  logic [CntW-1:0] e_next;

  assign lo_in = (in_data_i.id_a < in_data_i.id_b) ? in_data_i.id_a : in_data_i.id_b;
  assign hi_in = (in_data_i.id_a < in_data_i.id_b) ? in_data_i.id_b : in_data_i.id_a;
  assign e_next = e_rdata[CntW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    sweep_d = sweep_q;
    item_d = item_q;
    act_d = act_q;
    lo_d = lo_q;
    hi_d = hi_q;
    steps_d = steps_q;
    found_d = found_q;
    status_d = status_q;
    bucket_d = bucket_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    hash_start = 1'b0;
    b_we = 1'b0;
    b_re = 1'b0;
    b_waddr = sweep_q;
    b_wdata = '0;
    e_we = 1'b0;
    e_re = 1'b0;
    e_raddr = b_rdata[IdxW-1:0];
    e_wdata = {lo_q, hi_q, ChainEnd};
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLR: begin
        b_we = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == HASH_BITS'(Buckets - 1)) begin
          state_d = item_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_data_i.action;
          lo_d = lo_in;
          hi_d = hi_in;
          found_d = 1'b0;
          status_d = upsh_pkg::ST_OK;
          state_d = S_DONE;
          case (in_data_i.action)
            upsh_pkg::ACT_CLEAR: begin
              cnt_d = '0;
              sweep_d = '0;
              item_d = 1'b1;
              state_d = S_CLR;
            end
            upsh_pkg::ACT_INSERT: begin
              if (cnt_q == ChainEnd) begin
                status_d = upsh_pkg::ST_FULL;
              end else if (lo_in == 32'd0) begin
                status_d = upsh_pkg::ST_UNCHAINED;
              end else begin
                hash_start = 1'b1;
                state_d = S_HASH;
              end
            end
            upsh_pkg::ACT_QUERY: begin
              if (lo_in != 32'd0) begin
                hash_start = 1'b1;
                state_d = S_HASH;
              end
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bucket_d = bucket;
          b_re = 1'b1;
          state_d = S_BCHK;
        end
      end
      S_BCHK: begin
        state_d = S_DONE;
        if (act_q == upsh_pkg::ACT_INSERT) begin
          b_we = 1'b1;
          b_waddr = bucket_q;
          b_wdata = {1'b1, cnt_q[IdxW-1:0]};
          e_we = 1'b1;
          e_wdata = {lo_q, hi_q,
                     b_rdata[BktW-1] ? {1'b0, b_rdata[IdxW-1:0]} : ChainEnd};
          cnt_d = cnt_q + 1'b1;
        end else if (b_rdata[BktW-1] && ({1'b0, b_rdata[IdxW-1:0]} < cnt_q)) begin
          e_re = 1'b1;
          steps_d = '0;
          state_d = S_ECHK;
        end
      end
      S_ERD: begin
        e_re = 1'b1;
        e_raddr = e_next[IdxW-1:0];
        state_d = S_ECHK;
      end
      S_ECHK: begin
        state_d = S_DONE;
        if (e_rdata[EntW-1 -: 32] == lo_q && e_rdata[EntW-33 -: 32] == hi_q) begin
          found_d = 1'b1;
        end else if (e_next < cnt_q && e_next < ChainEnd &&
                     (steps_q + 1'b1) <= {2'b00, cnt_q}) begin
          steps_d = steps_q + 1'b1;
          e_re = 1'b1;
          e_raddr = e_next[IdxW-1:0];
          state_d = S_ECHK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.found = found_q;
          out_d.status = status_q;
          out_d.entry_total = cnt_q;
          if (act_q == upsh_pkg::ACT_INSERT && status_q == upsh_pkg::ST_UNCHAINED) begin
            e_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
            out_d.entry_total = cnt_q + 1'b1;
          end
          item_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q <= '0;
      sweep_q <= '0;
      item_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      sweep_q <= sweep_d;
      item_q <= item_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    steps_q <= steps_d;
    found_q <= found_d;
    status_q <= status_d;
    bucket_q <= bucket_d;
    out_q <= out_d;
  end

  upsh_hash #(.HashBits(HASH_BITS)) u_hash (
    .clk_i,
    .rst_ni,
    .start_i (hash_start),
    .key_i   ({lo_in, hi_in}),
    .done_o  (hash_done),
    .bucket_o(bucket)
  );

  upsh_ram #(.Width(BktW), .Depth(Buckets)) u_bucket_ram (
    .clk_i,
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(b_wdata),
    .re_i   (b_re),
    .raddr_i(bucket),
    .rdata_o(b_rdata)
  );

  upsh_ram #(.Width(EntW), .Depth(upsh_pkg::Capacity)) u_entry_ram (
    .clk_i,
    .we_i   (e_we),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(e_wdata),
    .re_i   (e_re),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
endmodule
`default_nettype wire

FILE: rtl/core/upsh_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module upsh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/upsh_hash.sv
// Multi-cycle splitmix64 finaliser over a 64-bit key, one 32x32 product a cycle.
// Depends on upsh_pkg.
`default_nettype none
module upsh_hash #(
  parameter int unsigned HashBits = upsh_pkg::HashBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [63:0]         key_i,
  output logic                     done_o,
  output logic      [HashBits-1:0] bucket_o
);
  logic [63:0] k_q, k_d, acc_q, acc_d, prod_q, prod_d, sum;
  logic [2:0]  step_q, step_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [HashBits-1:0] bucket_q, bucket_d;
  logic [31:0] op_a, op_b, c_lo, c_hi;
  logic [63:0] fin;

  assign c_lo = step_q[2] ? upsh_pkg::MixMul2[31:0] : upsh_pkg::MixMul1[31:0];
  assign c_hi = step_q[2] ? upsh_pkg::MixMul2[63:32] : upsh_pkg::MixMul1[63:32];
  assign op_a = (step_q[1:0] == 2'd1) ? k_q[63:32] : k_q[31:0];
  assign op_b = (step_q[1:0] == 2'd2) ? c_hi : c_lo;
  assign sum = acc_q + {prod_q[31:0], 32'd0};
  assign fin = sum ^ (sum >> 31);

  always_comb begin
    k_d = k_q;
    acc_d = acc_q;
    prod_d = prod_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    bucket_d = bucket_q;
    if (start_i) begin
      k_d = key_i ^ (key_i >> 30);
      step_d = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      case (step_q[1:0])
        2'd0: prod_d = op_a * op_b;
        2'd1: begin
          acc_d = prod_q;
          prod_d = op_a * op_b;
        end
        2'd2: begin
          acc_d = sum;
          prod_d = op_a * op_b;
        end
        default: begin
          if (!step_q[2]) begin
            k_d = sum ^ (sum >> 27);
          end else begin
            bucket_d = fin[HashBits-1:0];
            done_d = 1'b1;
            busy_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    acc_q <= acc_d;
    prod_q <= prod_d;
    bucket_q <= bucket_d;
  end

  assign done_o = done_q;
  assign bucket_o = bucket_q;
endmodule
`default_nettype wire

FILE: rtl/core/upsh_checker.sv
// Port-level checker for the unordered pair hash set, bound to the top level.
// Depends on upsh_pkg and unordered_pair_hash_set.
`default_nettype none
module upsh_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire upsh_pkg::out_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == upsh_pkg::ST_FULL |->
      out_data_o.entry_total == 11'(upsh_pkg::Capacity))
    else $error("drop flagged below capacity");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |->
      out_data_o.status == upsh_pkg::ST_OK && out_data_o.entry_total != 11'd0)
    else $error("hit with bad status or empty table");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer taken while busy");
endmodule

bind unordered_pair_hash_set upsh_checker u_upsh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

FILE: verif/tb_top.sv
// Testbench for the unordered pair hash set: directed table, then random
// clear/insert/query/unused items checked by an in-bench pair-set predictor.
// Depends on upsh_pkg and unordered_pair_hash_set.
`timescale 1ns / 1ps
module tb_top;
  localparam int unsigned Buckets = 1 << upsh_pkg::HashBitsDefault;
  localparam int unsigned Capacity = upsh_pkg::Capacity;
  localparam logic [1:0] ActUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  upsh_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  upsh_pkg::out_t out_data_o;

  always #2 clk_i = ~clk_i;

  unordered_pair_hash_set u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  // predictor state
  int unsigned pair_count;
  logic [31:0] low_ids[Capacity];
  logic [31:0] high_ids[Capacity];
  int unsigned link_next[Capacity];
  int unsigned head_of[Buckets];
  bit head_set[Buckets];

  upsh_pkg::out_t pending_results[$];
  int unsigned fail_count = 0;
  bit quiet = 1'b0;
  logic [31:0] id_pool[16];

  function automatic int unsigned bucket_index(logic [31:0] lo, logic [31:0] hi);
    logic [63:0] key;
    key = {lo, hi};
    key = key ^ (key >> 30);
    key = key * upsh_pkg::MixMul1;
    key = key ^ (key >> 27);
    key = key * upsh_pkg::MixMul2;
    key = key ^ (key >> 31);
    return int'(key[upsh_pkg::HashBitsDefault-1:0]);
  endfunction

  function automatic upsh_pkg::out_t predict_set_result(upsh_pkg::in_t item);
    upsh_pkg::out_t res;
    logic [31:0] lo, hi;
    int unsigned b, e, steps;
    res = '0;
    lo = (item.id_a < item.id_b) ? item.id_a : item.id_b;
    hi = (item.id_a < item.id_b) ? item.id_b : item.id_a;
    case (item.action)
      upsh_pkg::ACT_CLEAR: begin
        pair_count = 0;
        foreach (head_set[i]) head_set[i] = 1'b0;
      end
      upsh_pkg::ACT_INSERT: begin
        if (pair_count >= Capacity) begin
          res.status = upsh_pkg::ST_FULL;
        end else begin
          e = pair_count;
          low_ids[e] = lo;
          high_ids[e] = hi;
          if (lo == 0) begin
            link_next[e] = Capacity;
            res.status = upsh_pkg::ST_UNCHAINED;
          end else begin
            b = bucket_index(lo, hi);
            link_next[e] = head_set[b] ? head_of[b] : Capacity;
            head_of[b] = e;
            head_set[b] = 1'b1;
          end
          pair_count = e + 1;
        end
      end
      upsh_pkg::ACT_QUERY: begin
        if (lo != 0) begin
          b = bucket_index(lo, hi);
          if (head_set[b]) begin
            e = head_of[b];
            steps = 0;
            while (e < pair_count && e < Capacity && steps <= pair_count) begin
              if (low_ids[e] == lo && high_ids[e] == hi) begin
                res.found = 1'b1;
                break;
              end
              e = link_next[e];
              steps++;
            end
          end
        end
      end
      default: ;
    endcase
    res.entry_total = pair_count[10:0];
    return res;
  endfunction

  task automatic send_item(upsh_pkg::in_t item);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_set_result(item));
  endtask

  task automatic send_checked(upsh_pkg::in_t item, upsh_pkg::out_t want);
    upsh_pkg::out_t got;
    got = predict_set_result(item);
    pending_results.push_back(want);
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (got !== want) begin
      $error("directed row disagrees with predictor: want %h got %h", want, got);
      fail_count++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2, 3: return $urandom;
      default: return id_pool[$urandom_range(0, 15)];
    endcase
  endfunction

  // result checking
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", out_data_o);
        fail_count++;
      end else begin
        upsh_pkg::out_t want;
        want = pending_results.pop_front();
        if (out_data_o.found !== want.found) begin
          $error("found: expected %0d actual %0d", want.found, out_data_o.found);
          fail_count++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.entry_total !== want.entry_total) begin
          $error("entry_total: expected %0d actual %0d", want.entry_total,
                 out_data_o.entry_total);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int unsigned burst;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 13);
        out_ready_i <= 1'b0;
        repeat (burst) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  typedef struct {
    upsh_pkg::in_t item;
    upsh_pkg::out_t want;
    bit fixed;
  } row_t;

  initial begin
    row_t rows[$];
    upsh_pkg::in_t item;
    int unsigned r;
    foreach (head_set[i]) head_set[i] = 1'b0;
    pair_count = 0;
    foreach (id_pool[i]) id_pool[i] = (i < 2) ? 32'(i + 1) : $urandom;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back('{'{upsh_pkg::ACT_QUERY, 32'd5, 32'd7},
                     '{1'b0, upsh_pkg::ST_OK, 11'd0}, 1'b1});
    rows.push_back('{'{ActUnused, 32'hffff_ffff, 32'hffff_ffff},
                     '{1'b0, upsh_pkg::ST_OK, 11'd0}, 1'b1});
    rows.push_back('{'{upsh_pkg::ACT_INSERT, 32'd5, 32'd7},
                     '{1'b0, upsh_pkg::ST_OK, 11'd1}, 1'b1});
    rows.push_back('{'{upsh_pkg::ACT_QUERY, 32'd7, 32'd5},
                     '{1'b1, upsh_pkg::ST_OK, 11'd1}, 1'b1});
    rows.push_back('{'{upsh_pkg::ACT_QUERY, 32'd5, 32'd7},
                     '{1'b1, upsh_pkg::ST_OK, 11'd1}, 1'b1});
    rows.push_back('{'{upsh_pkg::ACT_INSERT, 32'd0, 32'd9},
                     '{1'b0, upsh_pkg::ST_UNCHAINED, 11'd2}, 1'b1});
    rows.push_back('{'{upsh_pkg::ACT_QUERY, 32'd9, 32'd0},
                     '{1'b0, upsh_pkg::ST_OK, 11'd2}, 1'b1});
    rows.push_back('{'{upsh_pkg::ACT_INSERT, 32'h0, 32'h0},
                     '{1'b0, upsh_pkg::ST_UNCHAINED, 11'd3}, 1'b1});
    rows.push_back('{'{upsh_pkg::ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff}, '0, 1'b0});
    rows.push_back('{'{upsh_pkg::ACT_QUERY, 32'hffff_ffff, 32'hffff_ffff}, '0, 1'b0});
    rows.push_back('{'{upsh_pkg::ACT_INSERT, 32'd7, 32'd5}, '0, 1'b0});
    rows.push_back('{'{upsh_pkg::ACT_QUERY, 32'd1, 32'hffff_ffff}, '0, 1'b0});
    rows.push_back('{'{upsh_pkg::ACT_INSERT, 32'hffff_ffff, 32'd1}, '0, 1'b0});
    rows.push_back('{'{upsh_pkg::ACT_QUERY, 32'd1, 32'hffff_ffff}, '0, 1'b0});
    rows.push_back('{'{ActUnused, 32'd1, 32'd2}, '0, 1'b0});
    rows.push_back('{'{upsh_pkg::ACT_CLEAR, 32'd0, 32'd0},
                     '{1'b0, upsh_pkg::ST_OK, 11'd0}, 1'b1});
    rows.push_back('{'{upsh_pkg::ACT_QUERY, 32'd5, 32'd7},
                     '{1'b0, upsh_pkg::ST_OK, 11'd0}, 1'b1});
    foreach (rows[i]) begin
      if (rows[i].fixed) send_checked(rows[i].item, rows[i].want);
      else send_item(rows[i].item);
    end

    // fill to capacity, then overflow
    for (int i = 0; i < Capacity + 16; i++) begin
      item.action = upsh_pkg::ACT_INSERT;
      item.id_a = (i % 50 == 0) ? 32'h0 : pick_id();
      item.id_b = pick_id();
      if (i % 97 == 0) item = '{upsh_pkg::ACT_QUERY, pick_id(), pick_id()};
      send_item(item);
    end
    wait_drained();
    send_checked('{upsh_pkg::ACT_INSERT, 32'd3, 32'd4},
                 '{1'b0, upsh_pkg::ST_FULL, 11'(Capacity)});
    for (int i = 0; i < 40; i++) send_item('{upsh_pkg::ACT_QUERY, pick_id(), pick_id()});
    send_item('{upsh_pkg::ACT_CLEAR, $urandom, $urandom});

    for (int i = 0; i < 580; i++) begin
      if (i == 520) begin
        wait_drained();
        quiet = 1'b1;
      end
      if (i % 8 == 0) id_pool[$urandom_range(0, 15)] = $urandom;
      r = $urandom_range(0, 99);
      item.id_a = pick_id();
      item.id_b = pick_id();
      if (r < 2) item.action = upsh_pkg::ACT_CLEAR;
      else if (r < 4) item.action = ActUnused;
      else if (r < 50) item.action = upsh_pkg::ACT_INSERT;
      else item.action = upsh_pkg::ACT_QUERY;
      send_item(item);
    end
    wait_drained();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

FILE: unordered_pair_hash_set.f
rtl/core/upsh_pkg.sv
rtl/core/upsh_ram.sv
rtl/core/upsh_hash.sv
rtl/core/unordered_pair_hash_set.sv
rtl/core/upsh_checker.sv
verif/tb_top.sv
